// File: src/fkf_pkg.sv
// package: widths, register codes and shared types of the free-run top-k finder
package fkf_pkg;

  // fixed field widths
  localparam int TOP_COUNT_W = 4;
  localparam int CLUSTER_W   = 21;
  localparam int START_W     = 23;
  localparam int KB_W        = 34;
  localparam int RANK_W      = 4;

  // kb conversion is a divide by 1024
  localparam int KB_SHIFT = 10;

  // configuration port
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_BYTES = 1'd1;

  // register reset values
  localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RST     = 4'd10;
  localparam logic [CLUSTER_W-1:0]   CLUSTER_BYTES_RST = 21'd4096;

  // default sizes
  localparam int DEF_TOP_ENTRIES = 10;
  localparam int DEF_MAP_BITS    = 8388608;

  // control from the run tracker to the ranked list
  typedef struct packed {
    logic insert;
    logic clear;
  } list_ctrl_t;

endpackage

// File: src/fkf_if.sv
// interfaces: bitmap input channel and report output channel

interface fkf_in_if import fkf_pkg::*; ();
  logic valid;
  logic ready;
  logic cluster_used;
  logic end_of_map;

  modport source (output valid, output cluster_used, output end_of_map, input ready);
  modport sink   (input valid, input cluster_used, input end_of_map, output ready);
endinterface

interface fkf_out_if import fkf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RANK_W-1:0]   rank;
  logic [KB_W-1:0]     length_kb;
  logic [START_W-1:0]  start_bit;
  logic                run_valid;
  logic                last_result;

  modport source (output valid, output rank, output length_kb, output start_bit,
                  output run_valid, output last_result, input ready);
  modport sink   (input valid, input rank, input length_kb, input start_bit,
                  input run_valid, input last_result, output ready);
endinterface

// File: src/fkf_rank_list.sv
// ranked list of the largest free runs with parallel compare-and-shift insertion
module fkf_rank_list import fkf_pkg::*; #(
  parameter int TOP_ENTRIES = DEF_TOP_ENTRIES,
  parameter int LEN_W       = 24,
  parameter int CNT_W       = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  list_ctrl_t          ctrl,
  input  logic [START_W-1:0]  ins_start,
  input  logic [LEN_W-1:0]    ins_len,
  output logic [START_W-1:0]  nxt_start [TOP_ENTRIES],
  output logic [LEN_W-1:0]    nxt_len   [TOP_ENTRIES],
  output logic [CNT_W-1:0]    nxt_count
);

  logic [START_W-1:0]   start_r [TOP_ENTRIES];
  logic [LEN_W-1:0]     len_r   [TOP_ENTRIES];
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [TOP_ENTRIES-1:0] keep;

  // entries that rank at or above the new run form a prefix of the list
  for (genvar i = 0; i < TOP_ENTRIES; i++) begin : g_cmp
    assign keep[i] = (CNT_W'(i) < count_r) && (len_r[i] >= ins_len);
  end

  // each slot keeps, takes the new run, or takes its upper neighbour
  for (genvar i = 0; i < TOP_ENTRIES; i++) begin : g_slot
    if (i == 0) begin : g_head
      always_comb begin
        if (!ctrl.insert || keep[i]) begin
          nxt_start[i] = start_r[i];
          nxt_len[i]   = len_r[i];
        end else begin
          nxt_start[i] = ins_start;
          nxt_len[i]   = ins_len;
        end
      end
    end else begin : g_body
      always_comb begin
        if (!ctrl.insert || keep[i]) begin
          nxt_start[i] = start_r[i];
          nxt_len[i]   = len_r[i];
        end else if (keep[i-1]) begin
          nxt_start[i] = ins_start;
          nxt_len[i]   = ins_len;
        end else begin
          nxt_start[i] = start_r[i-1];
          nxt_len[i]   = len_r[i-1];
        end
      end
    end
  end

  // a run is never dropped while the list has room
  always_comb begin
    nxt_count = count_r;
    if (ctrl.insert && (count_r < CNT_W'(TOP_ENTRIES))) begin
      nxt_count = count_r + CNT_W'(1);
    end
  end

  assign count_nxt = ctrl.clear ? '0 : nxt_count;

  // list contents
  always_ff @(posedge clk) begin
    for (int i = 0; i < TOP_ENTRIES; i++) begin
      start_r[i] <= nxt_start[i];
      len_r[i]   <= nxt_len[i];
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TOP_ENTRIES))
    else $error("list count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> count_r == '0)
    else $error("list not empty after clear");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.insert && !ctrl.clear && count_r < CNT_W'(TOP_ENTRIES))
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert into a list with room did not grow it");
`endif

endmodule

// File: src/free_run_top_k_finder.sv
// top level: free-run tracker, ranked list snapshot and report output stage
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        cluster_used, end_of_map
//  out_ch    out  valid/ready        rank, length_kb, start_bit, run_valid, last_result
//  cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
// one bitmap bit is taken every cycle; run tracking and the sorted insert finish in that cycle
// on end of map the list is copied to a report buffer and cleared, so the next map streams on
// the report drains one result per ready cycle through the output register (one multiply each)
// an end-of-map bit waits only while the previous report still has results to drain
// reset is synchronous: control and config registers return to defaults, no clearing pass
module free_run_top_k_finder import fkf_pkg::*; #(
  parameter int TOP_ENTRIES = DEF_TOP_ENTRIES,
  parameter int MAP_BITS    = DEF_MAP_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  fkf_in_if.sink                 in_ch,
  fkf_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PW     = $clog2(MAP_BITS + 1);
  localparam int CW     = $clog2(TOP_ENTRIES + 1);
  localparam int IW     = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;
  localparam int LIM_W  = (CW > TOP_COUNT_W) ? CW : TOP_COUNT_W;
  localparam int PROD_W = PW + CLUSTER_W;

  // configuration
  logic [TOP_COUNT_W-1:0] top_count_r;
  logic [CLUSTER_W-1:0]   cluster_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r     <= TOP_COUNT_RST;
      cluster_bytes_r <= CLUSTER_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOP_COUNT:     top_count_r     <= cfg_wdata[TOP_COUNT_W-1:0];
        CFG_CLUSTER_BYTES: cluster_bytes_r <= cfg_wdata[CLUSTER_W-1:0];
        default: ;
      endcase
    end
  end

  // run tracker state
  logic [PW-1:0]      bit_pos_r, bit_pos_nxt;
  logic               in_run_r, in_run_nxt;
  logic [START_W-1:0] run_start_r, run_start_nxt;
  logic [PW-1:0]      run_len_r, run_len_nxt;

  // report buffer and output stage
  logic [START_W-1:0] rep_start_r [TOP_ENTRIES];
  logic [PW-1:0]      rep_len_r   [TOP_ENTRIES];
  logic               rep_busy_r, rep_busy_nxt;
  logic [CW-1:0]      rep_n_r, rep_n_nxt;
  logic [CW-1:0]      rep_idx_r, rep_idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]  out_rank_r;
  logic [KB_W-1:0]    out_kb_r;
  logic [START_W-1:0] out_start_r;
  logic               out_runv_r;
  logic               out_last_r;

  logic               in_acc, in_map, free_bit, busy_bit, last_bit;
  logic               run_open_upd, close_now;
  logic [START_W-1:0] run_start_upd;
  logic [PW-1:0]      run_len_upd;

  logic               load_out, rep_final, rep_slot_free;
  logic [LIM_W-1:0]   limit;
  logic [CW-1:0]      report_n;
  logic [PROD_W-1:0]  prod;

  list_ctrl_t         list_ctrl;
  logic [START_W-1:0] nxt_start [TOP_ENTRIES];
  logic [PW-1:0]      nxt_len   [TOP_ENTRIES];
  logic [CW-1:0]      nxt_count;

  // input handshake: an end-of-map bit needs a free report buffer
  assign rep_final     = (rep_n_r == '0) || (rep_idx_r == rep_n_r - CW'(1));
  assign load_out      = rep_busy_r && (!out_valid_r || out_ch.ready);
  assign rep_slot_free = !rep_busy_r || (load_out && rep_final);
  assign in_ch.ready   = !in_ch.end_of_map || rep_slot_free;
  assign in_acc        = in_ch.valid && in_ch.ready;

  // current bit against the open run
  assign in_map   = bit_pos_r < PW'(MAP_BITS);
  assign free_bit = in_map && !in_ch.cluster_used;
  assign busy_bit = in_map && in_ch.cluster_used;
  assign last_bit = in_ch.end_of_map;

  always_comb begin
    run_open_upd  = in_run_r || free_bit;
    run_start_upd = run_start_r;
    run_len_upd   = run_len_r;
    if (free_bit) begin
      if (in_run_r) begin
        run_len_upd = run_len_r + PW'(1);
      end else begin
        run_start_upd = START_W'(bit_pos_r);
        run_len_upd   = PW'(1);
      end
    end
    close_now = run_open_upd && (busy_bit || last_bit);
  end

  // tracker next state
  always_comb begin
    bit_pos_nxt   = bit_pos_r;
    in_run_nxt    = in_run_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    if (in_acc) begin
      if (last_bit) begin
        bit_pos_nxt   = '0;
        in_run_nxt    = 1'b0;
        run_start_nxt = '0;
        run_len_nxt   = '0;
      end else begin
        bit_pos_nxt = bit_pos_r + PW'(in_map);
        if (close_now) begin
          in_run_nxt    = 1'b0;
          run_start_nxt = '0;
          run_len_nxt   = '0;
        end else begin
          in_run_nxt    = run_open_upd;
          run_start_nxt = run_start_upd;
          run_len_nxt   = run_len_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r   <= '0;
      in_run_r    <= 1'b0;
      run_start_r <= '0;
      run_len_r   <= '0;
    end else begin
      bit_pos_r   <= bit_pos_nxt;
      in_run_r    <= in_run_nxt;
      run_start_r <= run_start_nxt;
      run_len_r   <= run_len_nxt;
    end
  end

  // ranked list
  assign list_ctrl.insert = in_acc && close_now;
  assign list_ctrl.clear  = in_acc && last_bit;

  fkf_rank_list #(
    .TOP_ENTRIES (TOP_ENTRIES),
    .LEN_W       (PW),
    .CNT_W       (CW)
  ) u_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (list_ctrl),
    .ins_start (run_start_upd),
    .ins_len   (run_len_upd),
    .nxt_start (nxt_start),
    .nxt_len   (nxt_len),
    .nxt_count (nxt_count)
  );

  // number of results: list fill capped by top_count, zero or oversize meaning all
  always_comb begin
    if ((top_count_r == '0) || (LIM_W'(top_count_r) > LIM_W'(TOP_ENTRIES))) begin
      limit = LIM_W'(TOP_ENTRIES);
    end else begin
      limit = LIM_W'(top_count_r);
    end
    report_n = (LIM_W'(nxt_count) < limit) ? nxt_count : CW'(limit);
  end

  // report buffer contents, copied on end of map
  always_ff @(posedge clk) begin
    if (list_ctrl.clear) begin
      for (int i = 0; i < TOP_ENTRIES; i++) begin
        rep_start_r[i] <= nxt_start[i];
        rep_len_r[i]   <= nxt_len[i];
      end
    end
  end

  // report sequencing
  always_comb begin
    rep_busy_nxt = rep_busy_r;
    rep_n_nxt    = rep_n_r;
    rep_idx_nxt  = rep_idx_r;
    if (load_out) begin
      rep_idx_nxt = rep_idx_r + CW'(1);
      if (rep_final) begin
        rep_busy_nxt = 1'b0;
      end
    end
    if (list_ctrl.clear) begin
      rep_busy_nxt = 1'b1;
      rep_n_nxt    = report_n;
      rep_idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_busy_r <= 1'b0;
      rep_n_r    <= '0;
      rep_idx_r  <= '0;
    end else begin
      rep_busy_r <= rep_busy_nxt;
      rep_n_r    <= rep_n_nxt;
      rep_idx_r  <= rep_idx_nxt;
    end
  end

  // kb conversion of the entry being reported
  assign prod = PROD_W'(rep_len_r[rep_idx_r[IW-1:0]]) * PROD_W'(cluster_bytes_r);

  // output register
  assign out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (rep_n_r == '0) begin
        out_rank_r  <= '0;
        out_kb_r    <= '0;
        out_start_r <= '0;
        out_runv_r  <= 1'b0;
        out_last_r  <= 1'b1;
      end else begin
        out_rank_r  <= RANK_W'(rep_idx_r) + RANK_W'(1);
        out_kb_r    <= KB_W'(prod >> KB_SHIFT);
        out_start_r <= rep_start_r[rep_idx_r[IW-1:0]];
        out_runv_r  <= 1'b1;
        out_last_r  <= rep_final;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.rank        = out_rank_r;
  assign out_ch.length_kb   = out_kb_r;
  assign out_ch.start_bit   = out_start_r;
  assign out_ch.run_valid   = out_runv_r;
  assign out_ch.last_result = out_last_r;

`ifndef SYNTH
  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> rep_busy_r)
    else $error("input stalled with no report pending");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rep_busy_r && rep_n_r != '0) |-> rep_idx_r < rep_n_r)
    else $error("report index beyond result count");

  a_no_run_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_runv_r) |-> (out_last_r && out_rank_r == '0))
    else $error("empty-map result not a lone final result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rep_n_r <= CW'(TOP_ENTRIES))
    else $error("report count above list capacity");
`endif

endmodule
